>>> src/tamsd_pkg.sv
package tamsd_pkg;

	localparam int MAX_FRAMES_DEF = 1024;
	localparam int MAX_LAGS_DEF   = 1024;
	localparam int COORD_BITS_DEF = 24;

	localparam int TIME_W = 32;
	localparam int AVG_W  = 63;
	localparam int CNT_W  = 20;
	localparam int WIN_W  = 11;
	localparam int LAGI_W = 10;

	localparam logic [AVG_W-1:0] SUM_MAX = {AVG_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_DROP  = 2'd2;
	localparam logic [1:0] STAT_NOLAG = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_WIN_A,
		S_WIN_B,
		S_WIN_C,
		S_WIN_DIV,
		S_PAIR_I,
		S_PAIR_IL,
		S_PAIR_J,
		S_PAIR_JL,
		S_PAIR_DIV,
		S_PAIR_MUL,
		S_BIN_RD,
		S_BIN_WR,
		S_READ_RD,
		S_READ_LD,
		S_READ_DIV,
		S_RESULT
	} tamsd_state_t;

	// long_mode: 64 quotient bits, otherwise 33 (dividend in bits 32:0)
	typedef struct packed {
		logic start;
		logic long_mode;
	} div_req_t;

endpackage

>>> src/tamsd_ram.sv
module tamsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> src/tamsd_div.sv
module tamsd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tamsd_pkg::div_req_t req,
	input  logic [63:0]         dividend,
	input  logic [31:0]         divisor,
	output logic                done,
	output logic [63:0]         quotient
);
	import tamsd_pkg::*;

	logic [63:0] d_q;
	logic [32:0] r_q;
	logic [31:0] dv_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] r_sh;
	logic        fits;

	// shift in one dividend bit, subtract when the divisor fits
	assign r_sh = {r_q[31:0], d_q[63]};
	assign fits = r_sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 7'd1);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.long_mode ? 7'd64 : 7'd33;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q  <= req.long_mode ? dividend : {dividend[32:0], 31'd0};
			r_q  <= '0;
			dv_q <= divisor;
		end else if (run_q) begin
			r_q <= fits ? (r_sh - {1'b0, dv_q}) : r_sh;
			d_q <= {d_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = d_q;
endmodule

>>> src/time_averaged_msd_by_lag.sv
// Time-averaged mean squared displacement of one trajectory, binned by lag.
// Input channel (in_valid/in_ready): a load item (action 0) stores one frame,
// timestep plus x, y, z in signed Q11.12; a read item (action 1) asks for the
// averaged bin lag_index. Output channel (out_valid/out_ready): one result
// item per input item. Config channel (cfg_valid/cfg_ready, lag_spacing) is
// always ready and must only be written while the block is idle.
// A plain load, or a read of an unavailable lag, is answered in the cycle
// after acceptance and the next item can follow at once, so frames stream
// at one per cycle while results are taken. A load marked last_frame runs
// the computation: a clearing pass over the whole bin memory, the bin count
// from the shared bit-serial divider, then each frame pair through that
// divider and the bin read-modify-write. A valid read of a bin with pairs
// divides its sum by its pair count in the divider's long mode.
// in_ready is low while an item is being worked on, and also while a result
// waits in the output register and out_ready is low: a stalled receiver
// holds the block. Reset sets lag_spacing to 1 and empties the trajectory;
// frame and bin memories are not cleared by reset.
module time_averaged_msd_by_lag #(
	parameter int MAX_FRAMES = tamsd_pkg::MAX_FRAMES_DEF,
	parameter int MAX_LAGS   = tamsd_pkg::MAX_LAGS_DEF,
	parameter int COORD_BITS = tamsd_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tamsd_pkg::TIME_W-1:0]  lag_spacing,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [tamsd_pkg::TIME_W-1:0]  timestep,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic signed [COORD_BITS-1:0]  pos_z,
	input  logic                          last_frame,
	input  logic [tamsd_pkg::LAGI_W-1:0]  lag_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tamsd_pkg::AVG_W-1:0]   msd_average,
	output logic [tamsd_pkg::CNT_W-1:0]   pair_count,
	output logic [tamsd_pkg::WIN_W-1:0]   window_count,
	output logic [1:0]                    status
);
	import tamsd_pkg::*;

	localparam int FA_W  = $clog2(MAX_FRAMES);
	localparam int FC_W  = $clog2(MAX_FRAMES + 1);
	localparam int LA_W  = $clog2(MAX_LAGS);
	localparam int LC_W  = $clog2(MAX_LAGS + 1);
	localparam int CB    = COORD_BITS;
	localparam int FW    = TIME_W + 3 * CB;
	localparam int SQ_W  = 2 * (CB + 1);
	localparam int ACC_W = SQ_W + 2;
	localparam int BW    = AVG_W + CNT_W;

	tamsd_state_t state_q, state_d;

	logic [TIME_W-1:0] spacing_q;
	logic [TIME_W-1:0] sp;
	logic [FC_W-1:0]   fl_q;
	logic [LC_W-1:0]   liu_q;
	logic              rr_q;
	logic [FC_W-1:0]   i_q, j_q;
	logic [LA_W-1:0]   cc_q;
	logic [TIME_W-1:0] t0_q;
	logic [FW-1:0]     fi_q, fj_q;
	logic [LA_W-1:0]   lag_q;
	logic [1:0]        k_q;
	logic [SQ_W-1:0]   prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [1:0]        stat_q;
	logic              drop_q;

	logic [AVG_W-1:0] res_avg_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [1:0]       res_stat_q;

	logic             out_valid_q;
	logic [AVG_W-1:0] avg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIN_W-1:0] win_q;
	logic [1:0]       stat_out_q;

	// frame store
	logic            f_we;
	logic [FA_W-1:0] f_waddr, f_raddr;
	logic [FW-1:0]   f_wdata, f_rdata;
	// bin store: {sum, count}
	logic            b_we;
	logic [LA_W-1:0] b_waddr, b_raddr;
	logic [BW-1:0]   b_wdata, b_rdata;
	// shared divider
	div_req_t    div_req;
	logic [63:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [63:0] div_q;

	logic              accept, is_load, full, imm_out, read_ok;
	logic [FC_W-1:0]   fl_eff;
	logic [TIME_W-1:0] ti, tj, tl;
	logic [TIME_W-1:0] span;
	logic [34:0]       win;
	logic              more_j, more_i, pair_end, drop_now, finish;
	logic [SQ_W-1:0]   sq;
	logic [AVG_W-1:0]  b_sum;
	logic [CNT_W-1:0]  b_cnt;
	logic [63:0]       sum_t;
	logic [1:0]        fin_stat;
	logic              ld_out;
	logic [AVG_W-1:0]  ld_avg;
	logic [CNT_W-1:0]  ld_cnt;
	logic [WIN_W-1:0]  ld_win;
	logic [1:0]        ld_stat;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic signed [CB:0] d;
		logic [CB:0]        m;
		d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
		m = d[CB] ? (~d + 1'b1) : d;
		return SQ_W'(m * m);
	endfunction

	tamsd_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_frames (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	tamsd_ram #(.WIDTH(BW), .DEPTH(MAX_LAGS)) u_bins (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	tamsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_load   = (action == ACT_LOAD);

	// spacing zero counts as one
	assign sp = (spacing_q == '0) ? TIME_W'(1) : spacing_q;

	// a load after a finished computation starts a new trajectory
	assign fl_eff  = rr_q ? '0 : fl_q;
	assign full    = (fl_eff == FC_W'(MAX_FRAMES));
	assign read_ok = rr_q && (32'(lag_index) < 32'(liu_q));
	assign imm_out = accept && (is_load ? !last_frame : !read_ok);

	assign ti   = fi_q[FW-1 -: TIME_W];
	assign tj   = f_rdata[FW-1 -: TIME_W];
	assign tl   = f_rdata[FW-1 -: TIME_W];
	assign span = (tl >= t0_q) ? (tl - t0_q) : '0;
	assign win  = 35'(div_q[33:0]) + 35'd1;

	assign more_j = ({1'b0, j_q} + 1'b1) < {1'b0, fl_q};
	assign more_i = ({1'b0, i_q} + 2'd2) < {1'b0, fl_q};

	// squared displacement of the coordinate picked by k_q
	always_comb begin
		case (k_q)
			2'd0:    sq = sq_diff(fj_q[3*CB-1 -: CB], fi_q[3*CB-1 -: CB]);
			2'd1:    sq = sq_diff(fj_q[2*CB-1 -: CB], fi_q[2*CB-1 -: CB]);
			default: sq = sq_diff(fj_q[CB-1:0], fi_q[CB-1:0]);
		endcase
	end

	assign b_sum = b_rdata[BW-1 -: AVG_W];
	assign b_cnt = b_rdata[CNT_W-1:0];
	assign sum_t = {1'b0, b_sum} + 64'(acc_q);

	// pair finished (used or dropped) and what follows it
	always_comb begin
		drop_now = 1'b0;
		pair_end = 1'b0;
		case (state_q)
			S_PAIR_JL: begin
				drop_now = (tj < ti);
				pair_end = (tj < ti);
			end
			S_PAIR_DIV: begin
				drop_now = div_done && (div_q >= 64'(liu_q));
				pair_end = drop_now;
			end
			S_BIN_WR: pair_end = 1'b1;
			default: ;
		endcase
	end

	assign finish = (pair_end && !more_j && !more_i)
		|| ((state_q == S_WIN_DIV) && div_done && (fl_q < FC_W'(2)));
	assign fin_stat = (stat_q != STAT_OK) ? stat_q :
		((drop_q || drop_now) ? STAT_DROP : STAT_OK);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_load && last_frame) begin
						state_d = S_CLEAR;
					end else if (!is_load && read_ok) begin
						state_d = S_READ_RD;
					end
				end
			end
			S_CLEAR: begin
				if (cc_q == LA_W'(MAX_LAGS - 1)) begin
					state_d = S_WIN_A;
				end
			end
			S_WIN_A: state_d = S_WIN_B;
			S_WIN_B: state_d = S_WIN_C;
			S_WIN_C: state_d = S_WIN_DIV;
			S_WIN_DIV: begin
				if (div_done) begin
					state_d = finish ? S_RESULT : S_PAIR_I;
				end
			end
			S_PAIR_I:  state_d = S_PAIR_IL;
			S_PAIR_IL: state_d = S_PAIR_J;
			S_PAIR_J:  state_d = S_PAIR_JL;
			S_PAIR_JL: state_d = S_PAIR_DIV;
			S_PAIR_DIV: begin
				if (div_done) begin
					state_d = S_PAIR_MUL;
				end
			end
			S_PAIR_MUL: begin
				if (k_q == 2'd3) begin
					state_d = S_BIN_RD;
				end
			end
			S_BIN_RD:  state_d = S_BIN_WR;
			S_BIN_WR:  state_d = S_BIN_WR;
			S_READ_RD: state_d = S_READ_LD;
			S_READ_LD: state_d = (b_cnt == '0) ? S_RESULT : S_READ_DIV;
			S_READ_DIV: begin
				if (div_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// end of a pair overrides the plain transition
		if (pair_end) begin
			if (more_j) begin
				state_d = S_PAIR_J;
			end else if (more_i) begin
				state_d = S_PAIR_I;
			end else begin
				state_d = S_RESULT;
			end
		end
	end

	// memory, divider and output-load controls
	always_comb begin
		f_we         = 1'b0;
		f_waddr      = fl_eff[FA_W-1:0];
		f_wdata      = {timestep, pos_x, pos_y, pos_z};
		f_raddr      = '0;
		b_we         = 1'b0;
		b_waddr      = cc_q;
		b_wdata      = '0;
		b_raddr      = lag_q;
		div_req      = '0;
		div_dividend = 64'({1'b0, span} + 33'(sp) - 33'd1);
		div_divisor  = sp;
		ld_out       = 1'b0;
		ld_avg       = res_avg_q;
		ld_cnt       = res_cnt_q;
		ld_win       = WIN_W'(liu_q);
		ld_stat      = res_stat_q;
		unique case (state_q)
			S_IDLE: begin
				f_we = accept && is_load && !full;
				if (imm_out) begin
					ld_out = 1'b1;
					ld_avg = '0;
					ld_cnt = '0;
					if (is_load) begin
						ld_win  = rr_q ? '0 : WIN_W'(liu_q);
						ld_stat = full ? STAT_FULL : STAT_OK;
					end else begin
						ld_stat = STAT_NOLAG;
					end
				end
			end
			S_CLEAR: b_we = 1'b1;
			S_WIN_A: f_raddr = '0;
			S_WIN_B: f_raddr = FA_W'(fl_q - 1'b1);
			S_WIN_C: div_req.start = 1'b1;
			S_PAIR_I: f_raddr = i_q[FA_W-1:0];
			S_PAIR_J: f_raddr = j_q[FA_W-1:0];
			S_PAIR_JL: begin
				div_req.start = !(tj < ti);
				div_dividend  = 64'(tj - ti);
			end
			S_BIN_WR: begin
				b_we    = 1'b1;
				b_waddr = lag_q;
				b_wdata = {(sum_t[63] ? SUM_MAX : sum_t[AVG_W-1:0]),
					((b_cnt == CNT_MAX) ? b_cnt : b_cnt + 1'b1)};
			end
			S_READ_LD: begin
				div_req.start     = (b_cnt != '0);
				div_req.long_mode = 1'b1;
				div_dividend      = {1'b0, b_sum};
				div_divisor       = 32'(b_cnt);
			end
			S_RESULT: ld_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			spacing_q   <= TIME_W'(1);
			fl_q        <= '0;
			liu_q       <= '0;
			rr_q        <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			cc_q        <= '0;
			k_q         <= '0;
			drop_q      <= 1'b0;
			stat_q      <= STAT_OK;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				spacing_q <= lag_spacing;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && is_load) begin
				if (rr_q) begin
					liu_q <= '0;
					rr_q  <= 1'b0;
				end
				if (!full) begin
					fl_q <= fl_eff + 1'b1;
				end
				if (last_frame) begin
					stat_q <= full ? STAT_FULL : STAT_OK;
					drop_q <= 1'b0;
					cc_q   <= '0;
				end
			end
			if (state_q == S_CLEAR) begin
				cc_q <= cc_q + 1'b1;
			end
			if ((state_q == S_WIN_DIV) && div_done) begin
				liu_q <= (win > 35'(MAX_LAGS)) ? LC_W'(MAX_LAGS) : LC_W'(win);
				i_q   <= '0;
			end
			if (state_q == S_PAIR_IL) begin
				j_q <= i_q + 1'b1;
			end
			if (state_q == S_PAIR_JL || state_q == S_PAIR_DIV) begin
				k_q <= '0;
			end else if (state_q == S_PAIR_MUL) begin
				k_q <= k_q + 1'b1;
			end
			if (drop_now) begin
				drop_q <= 1'b1;
			end
			if (pair_end) begin
				if (more_j) begin
					j_q <= j_q + 1'b1;
				end else if (more_i) begin
					i_q <= i_q + 1'b1;
				end
			end
			if (finish) begin
				rr_q <= 1'b1;
			end
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (state_q == S_WIN_B) begin
			t0_q <= f_rdata[FW-1 -: TIME_W];
		end
		if (state_q == S_PAIR_IL) begin
			fi_q <= f_rdata;
		end
		if (state_q == S_PAIR_JL) begin
			fj_q <= f_rdata;
		end
		if (state_q == S_PAIR_DIV && div_done) begin
			lag_q <= div_q[LA_W-1:0];
		end
		if (accept && !is_load) begin
			lag_q <= LA_W'(lag_index);
		end
		if (state_q == S_PAIR_MUL) begin
			prod_q <= sq;
			acc_q  <= (k_q == 2'd0) ? '0 : acc_q + ACC_W'(prod_q);
		end
		if (finish) begin
			res_avg_q  <= '0;
			res_cnt_q  <= '0;
			res_stat_q <= fin_stat;
		end
		if (state_q == S_READ_LD) begin
			res_avg_q  <= '0;
			res_cnt_q  <= b_cnt;
			res_stat_q <= STAT_OK;
		end
		if (state_q == S_READ_DIV && div_done) begin
			res_avg_q <= div_q[AVG_W-1:0];
		end
		if (ld_out) begin
			avg_q      <= ld_avg;
			cnt_q      <= ld_cnt;
			win_q      <= ld_win;
			stat_out_q <= ld_stat;
		end
	end

	assign out_valid    = out_valid_q;
	assign msd_average  = avg_q;
	assign pair_count   = cnt_q;
	assign window_count = win_q;
	assign status       = stat_out_q;
endmodule

>>> tb/time_averaged_msd_by_lag_test.sv
module time_averaged_msd_by_lag_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tamsd_pkg::*;

	localparam int FRAME_DEPTH = MAX_FRAMES_DEF;
	localparam int LAG_DEPTH   = MAX_LAGS_DEF;
	localparam int CW          = COORD_BITS_DEF;
	// Longest quiet stretch: a 30-frame computation is 435 pairs plus the
	// bin clear, well under this.
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam longint unsigned SUM_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic                 action;
		logic [TIME_W-1:0]    timestep;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] pz;
		logic                 last;
		logic [LAGI_W-1:0]    lag;
	} frame_item_t;

	typedef struct {
		logic [AVG_W-1:0] avg;
		logic [CNT_W-1:0] pairs;
		logic [WIN_W-1:0] lags;
		logic [1:0]       st;
	} msd_result_t;

	// Block ports; the inputs are known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [TIME_W-1:0]    lag_spacing = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 action = ACT_LOAD;
	logic [TIME_W-1:0]    timestep = '0;
	logic signed [CW-1:0] pos_x = '0;
	logic signed [CW-1:0] pos_y = '0;
	logic signed [CW-1:0] pos_z = '0;
	logic                 last_frame = 1'b0;
	logic [LAGI_W-1:0]    lag_index = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [AVG_W-1:0]     msd_average;
	logic [CNT_W-1:0]     pair_count;
	logic [WIN_W-1:0]     window_count;
	logic [1:0]           status;

	time_averaged_msd_by_lag dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .lag_spacing(lag_spacing),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .timestep(timestep),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.last_frame(last_frame), .lag_index(lag_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.msd_average(msd_average), .pair_count(pair_count),
		.window_count(window_count), .status(status)
	);

	// Items waiting to be offered, and averages owed by the block
	frame_item_t pending_items[$];
	msd_result_t owed_results[$];
	frame_item_t cur_item;

	// Shadow copy of the trajectory and the lag bins
	logic [TIME_W-1:0]       spacing_now = 32'd1;
	logic [TIME_W-1:0]       traj_time[FRAME_DEPTH];
	longint                  traj_x[FRAME_DEPTH];
	longint                  traj_y[FRAME_DEPTH];
	longint                  traj_z[FRAME_DEPTH];
	longint unsigned         bin_sum[LAG_DEPTH];
	logic [CNT_W-1:0]        bin_pairs[LAG_DEPTH];
	int                      frames_held = 0;
	int                      bins_used = 0;
	bit                      have_bins = 0;

	bit in_took = 0;
	bit out_took = 0;
	bit failed = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;
	bit hold_rx_req = 0;
	int tx_gap = 0;
	int rx_wait = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int items_queued = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Bins in use for a trajectory from t_first to t_last: ceil(span/sp)+1, capped.
	function automatic int bins_needed(logic [31:0] t_first, logic [31:0] t_last,
			logic [31:0] sp_raw);
		longint unsigned sp, span, win;
		sp = (sp_raw == 0) ? 64'd1 : 64'(sp_raw);
		span = (t_last >= t_first) ? 64'(t_last) - 64'(t_first) : 64'd0;
		win = (span + sp - 1) / sp + 1;
		return (win > LAG_DEPTH) ? LAG_DEPTH : int'(win);
	endfunction

	function automatic longint unsigned sq_delta(longint a, longint b);
		longint d;
		d = a - b;
		if (d < 0)
			d = -d;
		return longint'(d) * longint'(d);
	endfunction

	// Clear the bins and sum every ordered frame pair; returns 1 if any pair was dropped.
	function automatic bit accumulate_bins();
		longint unsigned sp, diff, lag, sq;
		bit dropped;
		int i, j, k;
		sp = (spacing_now == 0) ? 64'd1 : 64'(spacing_now);
		dropped = 0;
		for (k = 0; k < LAG_DEPTH; k++) begin
			bin_sum[k] = 0;
			bin_pairs[k] = 0;
		end
		if (frames_held == 0) begin
			bins_used = 0;
			return 0;
		end
		bins_used = bins_needed(traj_time[0], traj_time[frames_held-1], spacing_now);
		for (i = 0; i < frames_held; i++) begin
			for (j = i + 1; j < frames_held; j++) begin
				if (traj_time[j] < traj_time[i]) begin
					dropped = 1;
					continue;
				end
				diff = 64'(traj_time[j]) - 64'(traj_time[i]);
				lag = diff / sp;
				if (lag >= bins_used) begin
					dropped = 1;
					continue;
				end
				sq = sq_delta(traj_x[j], traj_x[i]) + sq_delta(traj_y[j], traj_y[i])
					+ sq_delta(traj_z[j], traj_z[i]);
				bin_sum[lag] = (SUM_TOP - bin_sum[lag] < sq) ? SUM_TOP : bin_sum[lag] + sq;
				if (bin_pairs[lag] != CNT_MAX)
					bin_pairs[lag]++;
			end
		end
		have_bins = 1;
		return dropped;
	endfunction

	function automatic msd_result_t msd_predict(frame_item_t it);
		msd_result_t r;
		r.avg = '0;
		r.pairs = '0;
		r.st = STAT_OK;
		if (it.action == ACT_LOAD) begin
			if (have_bins) begin
				frames_held = 0;
				bins_used = 0;
				have_bins = 0;
			end
			if (frames_held < FRAME_DEPTH) begin
				traj_time[frames_held] = it.timestep;
				traj_x[frames_held] = longint'(it.px);
				traj_y[frames_held] = longint'(it.py);
				traj_z[frames_held] = longint'(it.pz);
				frames_held++;
			end else begin
				r.st = STAT_FULL;
			end
			if (it.last && accumulate_bins() && r.st == STAT_OK)
				r.st = STAT_DROP;
		end else if (!have_bins || it.lag >= bins_used) begin
			r.st = STAT_NOLAG;
		end else begin
			r.pairs = bin_pairs[it.lag];
			r.avg = (r.pairs != 0) ? AVG_W'(bin_sum[it.lag] / r.pairs) : '0;
		end
		r.lags = WIN_W'(bins_used);
		return r;
	endfunction

	// Sample both channels at the rising edge; predict, compare and watch for hangs.
	always @(posedge clk) begin
		msd_result_t want;
		in_took = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (in_took)
			owed_results.push_back(msd_predict(cur_item));
		if (out_took) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result: msd_average %0d status %0d", msd_average, status);
				failed = 1;
			end else begin
				want = owed_results.pop_front();
				if (msd_average !== want.avg) begin
					$error("msd_average: expected %0d, actual %0d", want.avg, msd_average);
					failed = 1;
				end
				if (pair_count !== want.pairs) begin
					$error("pair_count: expected %0d, actual %0d", want.pairs, pair_count);
					failed = 1;
				end
				if (window_count !== want.lags) begin
					$error("window_count: expected %0d, actual %0d", want.lags, window_count);
					failed = 1;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					failed = 1;
				end
			end
		end
		// Count only cycles in which nothing moves on any channel
		if (in_took || out_took || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** time_averaged_msd_by_lag: FAILED **");
			$finish;
		end
	end

	// Sender: hold an offered item until taken, then idle for a drawn gap.
	always @(negedge clk) begin
		logic next_valid;
		next_valid = 1'b0;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (in_valid && !in_took) begin
			next_valid = 1'b1;
		end else if (tx_gap > 0) begin
			tx_gap--;
		end else if (pending_items.size() != 0) begin
			cur_item = pending_items.pop_front();
			action <= cur_item.action;
			timestep <= cur_item.timestep;
			pos_x <= cur_item.px;
			pos_y <= cur_item.py;
			pos_z <= cur_item.pz;
			last_frame <= cur_item.last;
			lag_index <= cur_item.lag;
			next_valid = 1'b1;
			if ($urandom_range(0, 49) == 0)
				tx_burst = !tx_burst;
			tx_gap = tx_burst ? 0 : $urandom_range(0, 12);
		end
		in_valid <= next_valid;
	end

	// Receiver: draw a wait per result; on request hold off for a long stretch.
	always @(negedge clk) begin
		if (hold_rx_req) begin
			hold_left = HOLD_CYCLES;
			hold_rx_req = 0;
		end
		if (out_took) begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_load(logic [31:0] t, logic [CW-1:0] x, logic [CW-1:0] y,
			logic [CW-1:0] z, logic last);
		frame_item_t it;
		it.action = ACT_LOAD;
		it.timestep = t;
		it.px = x;
		it.py = y;
		it.pz = z;
		it.last = last;
		it.lag = LAGI_W'($urandom);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic push_read(logic [LAGI_W-1:0] lag, logic last);
		frame_item_t it;
		it.action = ACT_READ;
		it.timestep = $urandom;
		it.px = CW'($urandom);
		it.py = CW'($urandom);
		it.pz = CW'($urandom);
		it.last = last;
		it.lag = lag;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Wait until every item is taken and answered, then let the block settle.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || owed_results.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_spacing(logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		lag_spacing <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		spacing_now = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One trajectory: mostly ordered timesteps stepping around the spacing,
	// some disorder, optional reads slipped in before the last frame.
	task automatic add_trajectory(int n, int reads);
		longint unsigned sp, step;
		logic [31:0] t, t_first;
		logic [CW-1:0] x, y, z;
		bit walk;
		int win, k;
		sp = (spacing_now == 0) ? 64'd1 : 64'(spacing_now);
		t = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1000);
		t_first = t;
		walk = $urandom_range(0, 1);
		x = $urandom;
		y = $urandom;
		z = $urandom;
		for (k = 0; k < n; k++) begin
			if (k > 0) begin
				case ($urandom_range(0, 9))
					0: step = $urandom;
					1: step = 0;
					default: step = {$urandom, $urandom} % (sp * 3 + 1);
				endcase
				t = t + 32'(step);
				if ($urandom_range(0, 19) == 0)
					t = $urandom;
				if (walk) begin
					x = x + CW'($urandom_range(0, 8191)) - CW'(4096);
					y = y + CW'($urandom_range(0, 8191)) - CW'(4096);
					z = z + CW'($urandom_range(0, 8191)) - CW'(4096);
				end else begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end
			end
			if (k > 0 && $urandom_range(0, 15) == 0)
				push_read(LAGI_W'($urandom), $urandom_range(0, 1));
			push_load(t, x, y, z, k == n - 1);
		end
		win = bins_needed(t_first, t, spacing_now);
		for (k = 0; k < reads; k++) begin
			if ($urandom_range(0, 3) == 0)
				push_read(LAGI_W'($urandom), $urandom_range(0, 1));
			else
				push_read(LAGI_W'($urandom_range(0, win)), $urandom_range(0, 1));
		end
	endtask

	initial begin
		logic [31:0] spacing_plan[6];
		int p, quota, k;
		spacing_plan = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'd0};
		spacing_plan[4] = $urandom_range(2, 1000);
		spacing_plan[5] = $urandom;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed, under the reset spacing of 1: reads with nothing computed
		push_read('0, 1'b1);
		push_read({LAGI_W{1'b1}}, 1'b0);
		// Extreme positions and a span far beyond the bin limit
		push_load(32'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
		push_load(32'd1, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
		push_load(32'hFFFF_FFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 1'b1);
		push_read(10'd0, 1'b0);
		push_read(10'd1, 1'b1);
		push_read({LAGI_W{1'b1}}, 1'b0);
		// Last timestep below the first: one bin, the pair dropped
		push_load(32'd100, 24'h001000, 24'h000000, 24'h000000, 1'b0);
		push_load(32'd50, 24'h002000, 24'h000000, 24'h000000, 1'b1);
		push_read(10'd0, 1'b0);
		push_read(10'd1, 1'b0);
		// A lone frame, then two frames sharing a timestep
		push_load(32'd7, 24'h123456, 24'hFEDCBA, 24'h000000, 1'b1);
		push_read(10'd0, 1'b0);
		push_load(32'd9, 24'h000100, 24'h000200, 24'h000300, 1'b0);
		push_load(32'd9, 24'hFFFF00, 24'hFFFE00, 24'hFFFD00, 1'b1);
		push_read(10'd0, 1'b0);
		// Spacing of zero acts as one; spacing at its top leaves two bins
		write_spacing(32'd0);
		push_load(32'd10, 24'h000010, 24'h000000, 24'h000000, 1'b0);
		push_load(32'd12, 24'h000020, 24'h000000, 24'h000000, 1'b1);
		push_read(10'd2, 1'b0);
		write_spacing(32'hFFFF_FFFF);
		push_load(32'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		push_load(32'hFFFF_FFFF, 24'h800000, 24'h800000, 24'h800000, 1'b1);
		push_read(10'd1, 1'b0);
		push_read(10'd2, 1'b0);

		// Random phases, one spacing each
		quota = 115;
		for (p = 0; p < 6; p++) begin
			write_spacing(spacing_plan[p]);
			k = items_queued;
			if (p == 3) begin
				// Long receiver hold-off while a long trajectory keeps coming
				@(posedge clk);
				hold_rx_req = 1;
				add_trajectory(20, 4);
			end
			if (p == 1)
				add_trajectory(30, 6);
			while (items_queued - k < quota)
				add_trajectory($urandom_range(1, 10), $urandom_range(1, 8));
		end

		drain();
		repeat (50) @(negedge clk);
		if (!failed)
			$display("** time_averaged_msd_by_lag: PASSED **");
		else
			$display("** time_averaged_msd_by_lag: FAILED **");
		$finish;
	end

endmodule

>>> time_averaged_msd_by_lag.f
src/tamsd_pkg.sv
src/tamsd_ram.sv
src/tamsd_div.sv
src/time_averaged_msd_by_lag.sv
tb/time_averaged_msd_by_lag_test.sv
